/* design/assert_macros.svh */
// Assertion macros shared by the wheel speed reporter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define WSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define WSR_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

/* design/wsr_pkg.sv */
// Types and constants shared by the wheel speed reporter modules.
`default_nettype none

package wsr_pkg;

    localparam int DIST_W     = 12;
    localparam int INTERVAL_W = 16;
    localparam int REVS_W     = 4;
    localparam int TICKS_W    = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = REVS_W + DIST_W;
    localparam int QUOT_W     = PROD_W + 8;
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    localparam logic [CFG_ADDR_W-1:0] REG_DISTANCE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPORT_REVS  = 2'd2;

    localparam logic [DIST_W-1:0]     DIST_RESET     = 12'd133;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [REVS_W-1:0]     REVS_RESET     = 4'd10;

    localparam logic [REVS_W-1:0]  REVS_MAX  = 4'hF;
    localparam logic [TICKS_W-1:0] TICKS_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic                fire;
        logic [REVS_W-1:0]   revs;
        logic [TICKS_W-1:0]  ticks;
    } trk_report_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

/* design/wsr_tracker.sv */
// Sensor edge detection, revolution and tick counters, report decision.
`default_nettype none

module wsr_tracker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              tick,
    input  wire logic                              sensor_level,
    input  wire logic [wsr_pkg::INTERVAL_W-1:0]    max_interval,
    input  wire logic [wsr_pkg::REVS_W-1:0]        report_revs,
    output wsr_pkg::trk_report_t                   report
);

    logic                          pending_reg;
    logic                          last_reg;
    logic [wsr_pkg::REVS_W-1:0]    revs_reg;
    logic [wsr_pkg::TICKS_W-1:0]   ticks_reg;
    logic [wsr_pkg::REVS_W-1:0]    revs_next;
    logic [wsr_pkg::TICKS_W-1:0]   ticks_next;
    logic                          rise;

    // the held sample is judged one tick late
    assign rise = pending_reg & ~last_reg;

    always_comb begin
        revs_next = revs_reg;
        if (rise && revs_reg != wsr_pkg::REVS_MAX) begin
            revs_next = revs_reg + 1'b1;
        end
        ticks_next = ticks_reg;
        if (ticks_reg != wsr_pkg::TICKS_MAX) begin
            ticks_next = ticks_reg + 1'b1;
        end
        report.revs  = revs_next;
        report.ticks = ticks_next;
        report.fire  = tick && ((ticks_next > {1'b0, max_interval}) ||
                                (revs_next >= report_revs));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            last_reg    <= 1'b0;
            revs_reg    <= '0;
            ticks_reg   <= '0;
        end else if (tick) begin
            last_reg    <= pending_reg;
            pending_reg <= sensor_level;
            // clear both counters once a report is issued
            revs_reg    <= report.fire ? '0 : revs_next;
            ticks_reg   <= report.fire ? '0 : ticks_next;
        end
    end

endmodule

`default_nettype wire

/* design/wsr_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module wsr_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [wsr_pkg::QUOT_W-1:0]      dividend,
    input  wire logic [wsr_pkg::TICKS_W-1:0]     divisor,
    output logic      [wsr_pkg::QUOT_W-1:0]      quotient,
    output wsr_pkg::div_status_t                 status
);

    logic [wsr_pkg::QUOT_W-1:0]    q_reg;
    logic [wsr_pkg::QUOT_W-1:0]    q_next;
    logic [wsr_pkg::TICKS_W-1:0]   rem_reg;
    logic [wsr_pkg::TICKS_W-1:0]   rem_next;
    logic [wsr_pkg::TICKS_W-1:0]   divisor_reg;
    logic [wsr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [wsr_pkg::TICKS_W:0]     rem_shift;
    logic [wsr_pkg::TICKS_W:0]     diff;
    logic                          fits;

    always_comb begin
        rem_shift = {rem_reg, q_reg[wsr_pkg::QUOT_W-1]};
        diff      = rem_shift - {1'b0, divisor_reg};
        fits      = rem_shift >= {1'b0, divisor_reg};
        // remainder stays below the divisor, so the top bit drops
        rem_next  = fits ? diff[wsr_pkg::TICKS_W-1:0]
                         : rem_shift[wsr_pkg::TICKS_W-1:0];
        q_next    = {q_reg[wsr_pkg::QUOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wsr_pkg::DIV_CNT_W'(wsr_pkg::QUOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

/* design/wheel_speed_reporter_top.sv */
// Top level of the wheel speed reporter: config, sequencer and result register.
//
// s_ channel: one word per millisecond tick, carrying the wheel sensor sample.
// m_ channel: one speed report word (8.8 m/s, revolutions, interval ticks).
// cfg_ port: write distance_per_rev (0), max_interval (1), report_revs (2);
// index 3 is ignored. Write only while the block is idle.
// A tick that makes no report leaves s_ready high, so the next tick may follow
// in the next cycle. A tick that makes a report holds s_ready low while the
// restoring divider runs, one quotient bit per cycle for all 24 quotient bits;
// the report then waits in S_OUT until the result register is free, and it
// appears on m_ in the same cycle that s_ready returns for the next tick.
// A waiting report does not block the next tick, but a second report stalls
// in the sequencer until the receiver takes the first.
// Reset (aresetn low, synchronous) clears the counters, the sensor history,
// the result valid flag, and loads the default register values.
`default_nettype none

module wheel_speed_reporter_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [wsr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [wsr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_sensor_level,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [7:0]                        m_speed_whole,
    output logic      [7:0]                        m_speed_fraction,
    output logic      [wsr_pkg::REVS_W-1:0]        m_revolution_count,
    output logic      [wsr_pkg::TICKS_W-1:0]       m_interval_ticks
);

    logic [wsr_pkg::DIST_W-1:0]     dist_reg;
    logic [wsr_pkg::INTERVAL_W-1:0] interval_reg;
    logic [wsr_pkg::REVS_W-1:0]     revs_cfg_reg;

    wsr_pkg::seq_state_t            state_reg;
    wsr_pkg::seq_state_t            state_next;
    wsr_pkg::trk_report_t           rpt;
    wsr_pkg::div_status_t           div_st;
    logic                           tick;
    logic                           div_start;
    logic                           load_out;
    logic [wsr_pkg::PROD_W-1:0]     prod;
    logic [wsr_pkg::QUOT_W-1:0]     quot;
    logic [wsr_pkg::REVS_W-1:0]     hold_revs_reg;
    logic [wsr_pkg::TICKS_W-1:0]    hold_ticks_reg;
    logic                           m_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg     <= wsr_pkg::DIST_RESET;
            interval_reg <= wsr_pkg::INTERVAL_RESET;
            revs_cfg_reg <= wsr_pkg::REVS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                wsr_pkg::REG_DISTANCE: begin
                    dist_reg <= cfg_wdata[wsr_pkg::DIST_W-1:0];
                end
                wsr_pkg::REG_MAX_INTERVAL: begin
                    interval_reg <= cfg_wdata[wsr_pkg::INTERVAL_W-1:0];
                end
                wsr_pkg::REG_REPORT_REVS: begin
                    revs_cfg_reg <= cfg_wdata[wsr_pkg::REVS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = (state_reg == wsr_pkg::S_IDLE);
    assign tick    = s_valid && s_ready;

    wsr_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .sensor_level (s_sensor_level),
        .max_interval (interval_reg),
        .report_revs  (revs_cfg_reg),
        .report       (rpt)
    );

    assign prod = {{wsr_pkg::DIST_W{1'b0}}, rpt.revs} *
                  {{wsr_pkg::REVS_W{1'b0}}, dist_reg};

    wsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod, 8'h00}),
        .divisor  (rpt.ticks),
        .quotient (quot),
        .status   (div_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            wsr_pkg::S_IDLE: begin
                if (rpt.fire) begin
                    div_start  = 1'b1;
                    state_next = wsr_pkg::S_DIV;
                end
            end
            wsr_pkg::S_DIV: begin
                if (div_st.done) begin
                    state_next = wsr_pkg::S_OUT;
                end
            end
            wsr_pkg::S_OUT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = wsr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wsr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            hold_revs_reg  <= rpt.revs;
            hold_ticks_reg <= rpt.ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            // saturate the whole byte, keep the low quotient byte as is
            m_speed_whole      <= (|quot[wsr_pkg::QUOT_W-1:16]) ? 8'hFF : quot[15:8];
            m_speed_fraction   <= quot[7:0];
            m_revolution_count <= hold_revs_reg;
            m_interval_ticks   <= hold_ticks_reg;
        end
    end

    assign m_valid = m_valid_reg;

`include "assert_macros.svh"

    `WSR_NEVER(a_ready_while_dividing, s_ready && div_st.busy, "input ready during divide")
    `WSR_ASSERT(a_done_in_div, div_st.done |-> (state_reg == wsr_pkg::S_DIV), "stray divider done")
    `WSR_ASSERT(a_ticks_nonzero, m_valid |-> (m_interval_ticks != '0), "report with zero ticks")
    `WSR_ASSERT(a_start_leaves_idle, div_start |=> (state_reg == wsr_pkg::S_DIV), "divide not entered")

endmodule

`default_nettype wire
